/* rtl/fsc_pkg.sv */
// Shared types, constants and size tables of the fastener shape classifier.
// No dependencies; imported by fsc_classify, fsc_match and the core.
package fsc_pkg;

    localparam int LEN_W      = 16;
    localparam int ASPECT_W   = 20;
    localparam int CONF_W     = 16;
    localparam int IDX_W      = 3;
    localparam int TABLE_LEN  = 7;
    localparam int ASPECT_FRAC = 12;
    localparam int PROD_W     = CONF_W + ASPECT_W;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_BOLT    = 2'd1,
        CLS_NUT     = 2'd2
    } shape_class_t;

    typedef enum logic [2:0] {
        RSN_DEGENERATE      = 3'd0,
        RSN_ROD             = 3'd1,
        RSN_COMPACT_BORE    = 3'd2,
        RSN_COMPACT_NO_BORE = 3'd3,
        RSN_BETWEEN         = 3'd4
    } reason_t;

    typedef enum logic [2:0] {
        CFG_ROD_ASPECT_GATE      = 3'd0,
        CFG_COMPACT_ASPECT_GATE  = 3'd1,
        CFG_TIGHT_COMPACT_ASPECT = 3'd2,
        CFG_CONFIDENCE_CAP       = 3'd3,
        CFG_FIT_ERROR_GATE       = 3'd4,
        CFG_ROD_BASE_CONFIDENCE  = 3'd5,
        CFG_ROD_CONFIDENCE_SLOPE = 3'd6
    } cfg_index_t;

    localparam logic [ASPECT_W-1:0] RST_ROD_ASPECT_GATE      = 20'd10240;
    localparam logic [ASPECT_W-1:0] RST_COMPACT_ASPECT_GATE  = 20'd5734;
    localparam logic [ASPECT_W-1:0] RST_TIGHT_COMPACT_ASPECT = 20'd4915;
    localparam logic [CONF_W-1:0]   RST_CONFIDENCE_CAP       = 16'd58982;
    localparam logic [CONF_W-1:0]   RST_FIT_ERROR_GATE       = 16'd9830;
    localparam logic [CONF_W-1:0]   RST_ROD_BASE_CONFIDENCE  = 16'd36045;
    localparam logic [CONF_W-1:0]   RST_ROD_CONFIDENCE_SLOPE = 16'd5243;

    localparam logic [CONF_W-1:0] NUT_CONF_HIGH = 16'd49152;  // 0.75
    localparam logic [CONF_W-1:0] NUT_CONF_LOW  = 16'd39322;  // 0.6

    // Q8.8 mm: shaft diameters M3..M12, then hex across-flats M3..M12
    localparam logic [LEN_W-1:0] SHAFT_Q88 [TABLE_LEN] =
        '{16'd768, 16'd1024, 16'd1280, 16'd1536, 16'd2048, 16'd2560, 16'd3072};
    localparam logic [LEN_W-1:0] FLATS_Q88 [TABLE_LEN] =
        '{16'd1408, 16'd1792, 16'd2048, 16'd2560, 16'd3328, 16'd4096, 16'd4608};

    typedef struct packed {
        logic [ASPECT_W-1:0] rod_aspect_gate;
        logic [ASPECT_W-1:0] compact_aspect_gate;
        logic [ASPECT_W-1:0] tight_compact_aspect;
        logic [CONF_W-1:0]   confidence_cap;
        logic [CONF_W-1:0]   fit_error_gate;
        logic [CONF_W-1:0]   rod_base_confidence;
        logic [CONF_W-1:0]   rod_confidence_slope;
    } cfg_t;

    typedef struct packed {
        shape_class_t      shape_class;
        reason_t           reason_code;
        logic [CONF_W-1:0] class_confidence;
    } cls_side_t;

    typedef struct packed {
        shape_class_t      shape_class;
        logic [CONF_W-1:0] class_confidence;
        reason_t           reason_code;
        logic              nominal_valid;
        logic [IDX_W-1:0]  nominal_index;
        logic [LEN_W-1:0]  reference_mm;
        logic [CONF_W-1:0] fit_error;
        logic [CONF_W-1:0] nominal_confidence;
    } result_t;

    function automatic logic [LEN_W-1:0] size_ref(input logic nut, input logic [IDX_W-1:0] idx);
        logic [LEN_W-1:0] r;
        r = '0;
        for (int i = 0; i < TABLE_LEN; i++) begin
            if (idx == IDX_W'(i)) begin
                r = nut ? FLATS_Q88[i] : SHAFT_Q88[i];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/fsc_div_pipe.sv */
// Pipelined restoring divider, up to BPS quotient bits per register stage.
// Caller guarantees in_hi < in_div so the quotient fits QW bits.
module fsc_div_pipe #(
    parameter int QW  = 20,
    parameter int DW  = 16,
    parameter int BPS = 4,
    parameter int SW  = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_hi,
    input  logic [QW-1:0] in_lo,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quot,
    output logic [SW-1:0] out_side
);

    localparam int STAGES = (QW + BPS - 1) / BPS;

    logic          valid_reg [STAGES];
    logic [DW-1:0] rem_reg   [STAGES];
    logic [QW-1:0] lo_reg    [STAGES];
    logic [QW-1:0] quot_reg  [STAGES];
    logic [DW-1:0] div_reg   [STAGES];
    logic [SW-1:0] side_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int NB = ((QW - s * BPS) < BPS) ? (QW - s * BPS) : BPS;

        logic          prev_valid;
        logic [DW-1:0] prev_rem;
        logic [QW-1:0] prev_lo;
        logic [QW-1:0] prev_quot;
        logic [DW-1:0] prev_div;
        logic [SW-1:0] prev_side;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] lo_next;
        logic [QW-1:0] quot_next;

        if (s == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_hi;
            assign prev_lo    = in_lo;
            assign prev_quot  = '0;
            assign prev_div   = in_div;
            assign prev_side  = in_side;
        end else begin : g_rest
            assign prev_valid = valid_reg[s-1];
            assign prev_rem   = rem_reg[s-1];
            assign prev_lo    = lo_reg[s-1];
            assign prev_quot  = quot_reg[s-1];
            assign prev_div   = div_reg[s-1];
            assign prev_side  = side_reg[s-1];
        end

        always_comb begin
            logic [DW:0] trial;
            logic        ge;
            rem_next  = prev_rem;
            lo_next   = prev_lo;
            quot_next = prev_quot;
            for (int j = 0; j < NB; j++) begin
                trial   = {rem_next, lo_next[QW-1]};
                lo_next = lo_next << 1;
                ge      = (trial >= {1'b0, prev_div});
                if (ge) begin
                    rem_next = DW'(trial - {1'b0, prev_div});
                end else begin
                    rem_next = trial[DW-1:0];
                end
                quot_next = (quot_next << 1) | QW'(ge);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                lo_reg[s]   <= lo_next;
                quot_reg[s] <= quot_next;
                div_reg[s]  <= prev_div;
                side_reg[s] <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

/* rtl/fsc_classify.sv */
// Aspect gating and class confidence, two register stages.
// Depends on fsc_pkg (cfg_t, cls_side_t, class and reason codes).
module fsc_classify (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  fsc_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    input  logic [fsc_pkg::ASPECT_W-1:0] in_aspect,
    input  logic                         in_degen,
    input  logic                         in_bore_nz,
    input  logic [fsc_pkg::LEN_W-1:0]    in_width,
    output logic                         out_valid,
    output fsc_pkg::cls_side_t           out_side,
    output logic [fsc_pkg::LEN_W-1:0]    out_width
);
    import fsc_pkg::*;

    localparam int SUM_W = PROD_W - ASPECT_FRAC + 1;

    // first stage: gates and gain product
    shape_class_t        cls_next;
    reason_t             reason_next;
    logic [PROD_W-1:0]   prod_next;
    logic [ASPECT_W-1:0] diff;

    logic                valid1_reg;
    shape_class_t        cls_reg;
    reason_t             reason_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                tight_reg;
    logic [LEN_W-1:0]    width1_reg;

    always_comb begin
        diff      = in_aspect - cfg.rod_aspect_gate;
        prod_next = PROD_W'(cfg.rod_confidence_slope) * PROD_W'(diff);
        if (in_degen) begin
            cls_next    = CLS_UNKNOWN;
            reason_next = RSN_DEGENERATE;
        end else if (in_aspect >= cfg.rod_aspect_gate) begin
            cls_next    = CLS_BOLT;
            reason_next = RSN_ROD;
        end else if (in_aspect <= cfg.compact_aspect_gate) begin
            cls_next    = in_bore_nz ? CLS_NUT : CLS_UNKNOWN;
            reason_next = in_bore_nz ? RSN_COMPACT_BORE : RSN_COMPACT_NO_BORE;
        end else begin
            cls_next    = CLS_UNKNOWN;
            reason_next = RSN_BETWEEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls_reg    <= cls_next;
            reason_reg <= reason_next;
            prod_reg   <= prod_next;
            tight_reg  <= (in_aspect <= cfg.tight_compact_aspect);
            width1_reg <= in_width;
        end
    end

    // second stage: confidence, capped
    logic [SUM_W-1:0]  bolt_sum;
    logic [CONF_W-1:0] nut_conf;
    cls_side_t         side_next;

    logic              valid2_reg;
    cls_side_t         side_reg;
    logic [LEN_W-1:0]  width2_reg;

    always_comb begin
        bolt_sum = SUM_W'(cfg.rod_base_confidence) + SUM_W'(prod_reg[PROD_W-1:ASPECT_FRAC]);
        nut_conf = tight_reg ? NUT_CONF_HIGH : NUT_CONF_LOW;
        side_next.shape_class = cls_reg;
        side_next.reason_code = reason_reg;
        case (cls_reg)
            CLS_BOLT: begin
                side_next.class_confidence = (bolt_sum > SUM_W'(cfg.confidence_cap)) ?
                    cfg.confidence_cap : bolt_sum[CONF_W-1:0];
            end
            CLS_NUT: begin
                side_next.class_confidence = (nut_conf > cfg.confidence_cap) ?
                    cfg.confidence_cap : nut_conf;
            end
            default: begin
                side_next.class_confidence = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg   <= side_next;
            width2_reg <= width1_reg;
        end
    end

    assign out_valid = valid2_reg;
    assign out_side  = side_reg;
    assign out_width = width2_reg;

endmodule

/* rtl/fsc_match.sv */
// Nearest table entry search: distance stage, then first-minimum stage.
// Depends on fsc_pkg (size tables, size_ref).
module fsc_match #(
    parameter int SCAN_N = 7,
    parameter int SW     = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      in_nut,
    input  logic [fsc_pkg::LEN_W-1:0] in_width,
    input  logic [SW-1:0]             in_side,
    output logic                      out_valid,
    output logic [fsc_pkg::IDX_W-1:0] out_index,
    output logic [fsc_pkg::LEN_W-1:0] out_dist,
    output logic [fsc_pkg::LEN_W-1:0] out_ref,
    output logic [SW-1:0]             out_side
);
    import fsc_pkg::*;

    logic [LEN_W-1:0] dist_next [TABLE_LEN];
    logic [LEN_W-1:0] dist_reg  [TABLE_LEN];
    logic             valid1_reg;
    logic             nut_reg;
    logic [SW-1:0]    side1_reg;

    always_comb begin
        logic [LEN_W-1:0] r;
        for (int i = 0; i < TABLE_LEN; i++) begin
            r = in_nut ? FLATS_Q88[i] : SHAFT_Q88[i];
            dist_next[i] = (in_width > r) ? (in_width - r) : (r - in_width);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg  <= dist_next;
            nut_reg   <= in_nut;
            side1_reg <= in_side;
        end
    end

    // strict less-than keeps the first entry on ties
    logic [IDX_W-1:0] best_idx;
    logic [LEN_W-1:0] best_dist;

    always_comb begin
        best_idx  = '0;
        best_dist = dist_reg[0];
        for (int i = 1; i < TABLE_LEN; i++) begin
            if (i < SCAN_N && dist_reg[i] < best_dist) begin
                best_idx  = IDX_W'(i);
                best_dist = dist_reg[i];
            end
        end
    end

    logic             valid2_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [LEN_W-1:0] dist2_reg;
    logic [LEN_W-1:0] ref_reg;
    logic [SW-1:0]    side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg   <= best_idx;
            dist2_reg <= best_dist;
            ref_reg   <= size_ref(nut_reg, best_idx);
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = valid2_reg;
    assign out_index = idx_reg;
    assign out_dist  = dist2_reg;
    assign out_ref   = ref_reg;
    assign out_side  = side2_reg;

endmodule

/* rtl/fastener_shape_classifier_core.sv */
// Fastener shape classifier: aspect, class, nominal size match per object.
// One word per cycle sustained while the skid slot is empty; a full slot stalls
// the whole pipeline. The three dividers are 4-bit-per-stage pipelines, so depth
// is set by their 20-, 16- and 17-bit quotients plus in/out regs and classify/match.
// aresetn (sync, active low) empties the pipeline and loads register defaults.
// Depends on fsc_pkg, fsc_div_pipe, fsc_classify, fsc_match.
module fastener_shape_classifier_core #(
    parameter int SIZE_ENTRIES = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // length_mm[15:0], width_mm[31:16], bore_count[39:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    // shape_class[1:0], class_confidence[17:2], reason_code[20:18], nominal_valid[21],
    // nominal_index[24:22], reference_mm[40:25], fit_error[56:41],
    // nominal_confidence[72:57], zero fill [79:73]
    output logic [79:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_wdata
);
    import fsc_pkg::*;

    localparam int SCAN_N = (SIZE_ENTRIES > TABLE_LEN) ? TABLE_LEN :
                            ((SIZE_ENTRIES < 1) ? 1 : SIZE_ENTRIES);
    localparam logic [CONF_W:0] CONF_ONE = {1'b1, {CONF_W{1'b0}}};

    typedef struct packed {
        logic [LEN_W-1:0] width;
        logic             bore_nz;
        logic             degen;
        logic             sat;
    } asp_side_t;

    typedef struct packed {
        cls_side_t        cls;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] ref_mm;
        logic             sat;
    } rel_side_t;

    typedef struct packed {
        cls_side_t         cls;
        logic              accept;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  ref_mm;
        logic [CONF_W-1:0] rel;
    } fit_side_t;

    // configuration registers
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rod_aspect_gate      <= RST_ROD_ASPECT_GATE;
            cfg_reg.compact_aspect_gate  <= RST_COMPACT_ASPECT_GATE;
            cfg_reg.tight_compact_aspect <= RST_TIGHT_COMPACT_ASPECT;
            cfg_reg.confidence_cap       <= RST_CONFIDENCE_CAP;
            cfg_reg.fit_error_gate       <= RST_FIT_ERROR_GATE;
            cfg_reg.rod_base_confidence  <= RST_ROD_BASE_CONFIDENCE;
            cfg_reg.rod_confidence_slope <= RST_ROD_CONFIDENCE_SLOPE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROD_ASPECT_GATE:      cfg_reg.rod_aspect_gate      <= cfg_wdata;
                CFG_COMPACT_ASPECT_GATE:  cfg_reg.compact_aspect_gate  <= cfg_wdata;
                CFG_TIGHT_COMPACT_ASPECT: cfg_reg.tight_compact_aspect <= cfg_wdata;
                CFG_CONFIDENCE_CAP:       cfg_reg.confidence_cap       <= cfg_wdata[CONF_W-1:0];
                CFG_FIT_ERROR_GATE:       cfg_reg.fit_error_gate       <= cfg_wdata[CONF_W-1:0];
                CFG_ROD_BASE_CONFIDENCE:  cfg_reg.rod_base_confidence  <= cfg_wdata[CONF_W-1:0];
                CFG_ROD_CONFIDENCE_SLOPE: cfg_reg.rod_confidence_slope <= cfg_wdata[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves together; only a full skid slot holds it
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // input stage
    logic             in_valid_reg;
    logic [LEN_W-1:0] length_mm_reg;
    logic [LEN_W-1:0] width_mm_reg;
    logic [7:0]       bore_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            length_mm_reg  <= s_tdata[15:0];
            width_mm_reg   <= s_tdata[31:16];
            bore_count_reg <= s_tdata[39:32];
        end
    end

    // aspect = (length << 12) / width; saturates when length >> 8 reaches width
    asp_side_t        asp_in_side;
    logic [LEN_W-1:0] asp_hi;
    logic [LEN_W-1:0] len_top;

    always_comb begin
        len_top             = {8'b0, length_mm_reg[15:8]};
        asp_in_side.width   = width_mm_reg;
        asp_in_side.bore_nz = (bore_count_reg != 8'd0);
        asp_in_side.degen   = (length_mm_reg == '0) || (width_mm_reg == '0);
        asp_in_side.sat     = (len_top >= width_mm_reg);
        asp_hi              = asp_in_side.sat ? '0 : len_top;
    end

    logic                asp_valid;
    logic [ASPECT_W-1:0] asp_quot;
    asp_side_t           asp_side;

    fsc_div_pipe #(
        .QW (ASPECT_W),
        .DW (LEN_W),
        .BPS(4),
        .SW ($bits(asp_side_t))
    ) u_aspect_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid_reg),
        .in_hi    (asp_hi),
        .in_lo    ({length_mm_reg[7:0], {ASPECT_FRAC{1'b0}}}),
        .in_div   (width_mm_reg),
        .in_side  (asp_in_side),
        .out_valid(asp_valid),
        .out_quot (asp_quot),
        .out_side (asp_side)
    );

    logic [ASPECT_W-1:0] aspect;
    assign aspect = asp_side.sat ? {ASPECT_W{1'b1}} : asp_quot;

    logic             cls_valid;
    cls_side_t        cls_side;
    logic [LEN_W-1:0] cls_width;

    fsc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (asp_valid),
        .in_aspect (aspect),
        .in_degen  (asp_side.degen),
        .in_bore_nz(asp_side.bore_nz),
        .in_width  (asp_side.width),
        .out_valid (cls_valid),
        .out_side  (cls_side),
        .out_width (cls_width)
    );

    logic             mt_valid;
    logic [IDX_W-1:0] mt_index;
    logic [LEN_W-1:0] mt_dist;
    logic [LEN_W-1:0] mt_ref;
    cls_side_t        mt_side;

    fsc_match #(
        .SCAN_N(SCAN_N),
        .SW    ($bits(cls_side_t))
    ) u_match (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cls_valid),
        .in_nut   (cls_side.shape_class == CLS_NUT),
        .in_width (cls_width),
        .in_side  (cls_side),
        .out_valid(mt_valid),
        .out_index(mt_index),
        .out_dist (mt_dist),
        .out_ref  (mt_ref),
        .out_side (mt_side)
    );

    // relative error = (dist << 16) / ref, saturating when dist reaches ref
    rel_side_t        rel_in_side;
    logic [LEN_W-1:0] rel_hi;

    always_comb begin
        rel_in_side.cls    = mt_side;
        rel_in_side.idx    = mt_index;
        rel_in_side.ref_mm = mt_ref;
        rel_in_side.sat    = (mt_dist >= mt_ref);
        rel_hi             = rel_in_side.sat ? '0 : mt_dist;
    end

    logic              rel_valid;
    logic [CONF_W-1:0] rel_quot;
    rel_side_t         rel_side;

    fsc_div_pipe #(
        .QW (CONF_W),
        .DW (LEN_W),
        .BPS(4),
        .SW ($bits(rel_side_t))
    ) u_rel_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (mt_valid),
        .in_hi    (rel_hi),
        .in_lo    ('0),
        .in_div   (mt_ref),
        .in_side  (rel_in_side),
        .out_valid(rel_valid),
        .out_quot (rel_quot),
        .out_side (rel_side)
    );

    // nominal confidence term = (rel << 16) / gate; rel <= gate keeps it <= 65536
    fit_side_t fit_in_side;

    always_comb begin
        fit_in_side.cls    = rel_side.cls;
        fit_in_side.idx    = rel_side.idx;
        fit_in_side.ref_mm = rel_side.ref_mm;
        fit_in_side.rel    = rel_side.sat ? {CONF_W{1'b1}} : rel_quot;
        fit_in_side.accept = (rel_side.cls.shape_class != CLS_UNKNOWN) &&
                             (fit_in_side.rel <= cfg_reg.fit_error_gate);
    end

    logic              fit_valid;
    logic [CONF_W:0]   fit_quot;
    fit_side_t         fit_side;

    fsc_div_pipe #(
        .QW (CONF_W + 1),
        .DW (CONF_W),
        .BPS(4),
        .SW ($bits(fit_side_t))
    ) u_conf_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rel_valid),
        .in_hi    ({1'b0, fit_in_side.rel[CONF_W-1:1]}),
        .in_lo    ({fit_in_side.rel[0], {CONF_W{1'b0}}}),
        .in_div   (cfg_reg.fit_error_gate),
        .in_side  (fit_in_side),
        .out_valid(fit_valid),
        .out_quot (fit_quot),
        .out_side (fit_side)
    );

    // result assembly
    result_t           fin_data;
    logic [CONF_W:0]   nconf_raw;
    logic [CONF_W-1:0] nconf;

    always_comb begin
        nconf_raw = CONF_ONE - fit_quot;
        if (cfg_reg.fit_error_gate == '0) begin
            nconf = cfg_reg.confidence_cap;        // only an exact fit gets here
        end else if (nconf_raw > {1'b0, cfg_reg.confidence_cap}) begin
            nconf = cfg_reg.confidence_cap;
        end else begin
            nconf = nconf_raw[CONF_W-1:0];
        end
        fin_data.shape_class      = fit_side.cls.shape_class;
        fin_data.class_confidence = fit_side.cls.class_confidence;
        fin_data.reason_code      = fit_side.cls.reason_code;
        fin_data.nominal_valid    = fit_side.accept;
        if (fit_side.accept) begin
            fin_data.nominal_index      = fit_side.idx;
            fin_data.reference_mm       = fit_side.ref_mm;
            fin_data.fit_error          = fit_side.rel;
            fin_data.nominal_confidence = nconf;
        end else begin
            fin_data.nominal_index      = '0;
            fin_data.reference_mm       = '0;
            fin_data.fit_error          = '0;
            fin_data.nominal_confidence = '0;
        end
    end

    // output register plus one skid slot
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= fit_valid;
        end else if (fit_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_data_reg <= fin_data;
        end else begin
            skid_data_reg <= fin_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0,
                       out_data_reg.nominal_confidence,
                       out_data_reg.fit_error,
                       out_data_reg.reference_mm,
                       out_data_reg.nominal_index,
                       out_data_reg.nominal_valid,
                       out_data_reg.reason_code,
                       out_data_reg.class_confidence,
                       out_data_reg.shape_class};

    // a word in the skid slot always has one ahead of it
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with output register empty");

    a_unknown_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.shape_class == CLS_UNKNOWN) |->
        (out_data_reg.class_confidence == '0 && !out_data_reg.nominal_valid))
        else $error("unknown class carries confidence or size match");

    a_rod_is_bolt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
        ((out_data_reg.reason_code == RSN_ROD) == (out_data_reg.shape_class == CLS_BOLT)))
        else $error("rod reason and bolt class disagree");

    a_fit_within_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.nominal_valid) |->
        (out_data_reg.fit_error <= cfg_reg.fit_error_gate))
        else $error("accepted match above fit error gate");

    a_index_scanned: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.nominal_valid) |->
        (out_data_reg.nominal_index < IDX_W'(SCAN_N)))
        else $error("matched index beyond scanned entries");

endmodule
